@@ rtl/cwr_pkg.sv @@
// Shared types, constants and fixed-point helpers for the circle/wall
// collision response unit. No dependencies.
`timescale 1ns / 1ps

package cwr_pkg;

   localparam int Q_ONE       = 65536;
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 18;
   localparam int LATENCY     = 58;
   localparam logic [16:0] REST_RESET = 17'd39322;

   typedef enum logic [2:0] {
      CASE_OUTSIDE = 3'd0,
      CASE_LEFT    = 3'd1,
      CASE_RIGHT   = 3'd2,
      CASE_TOP     = 3'd3,
      CASE_BOTTOM  = 3'd4
   } case_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [30:0]        circle_radius;
      logic signed [31:0] rect_left;
      logic signed [31:0] rect_top;
      logic [30:0]        rect_width;
      logic [30:0]        rect_height;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic [2:0]         contact_case;
      logic               bounced;
   } rsp_type;

   typedef struct packed {
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic               dx_neg;
      logic               dy_neg;
      logic [31:0]        ax;
      logic [31:0]        ay;
      logic               shift;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [30:0]        radius;
      case_type           contact;
      logic signed [35:0] in_npx;
      logic signed [35:0] in_npy;
   } side_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [47:0] rem_x;
      logic [47:0] rem_y;
      logic [17:0] q_x;
      logic [17:0] q_y;
      logic [32:0] den;
   } div_type;

   function automatic logic signed [63:0] tdiv16(input logic signed [63:0] v);
      logic signed [63:0] mag;
      mag = v[63] ? -v : v;
      mag = mag >>> 16;
      return v[63] ? -mag : mag;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

@@ rtl/cwr_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
// Depends on cwr_pkg.
`timescale 1ns / 1ps

module cwr_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  cwr_pkg::sqrt_type data_in,
   input  cwr_pkg::side_type side_in,
   output logic              valid_out,
   output cwr_pkg::sqrt_type data_out,
   output cwr_pkg::side_type side_out
);
   import cwr_pkg::*;

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic        valid_ff;
   sqrt_type    data_ff, data_in_n;
   side_type    side_ff;
   logic [63:0] trial;

   always_comb begin
      trial = data_in.root + BIT;
      if (data_in.rem >= trial) begin
         data_in_n.rem  = data_in.rem - trial;
         data_in_n.root = (data_in.root >> 1) + BIT;
      end else begin
         data_in_n.rem  = data_in.rem;
         data_in_n.root = data_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_n;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
   assign side_out  = side_ff;
endmodule

@@ rtl/cwr_div_cell.sv @@
// One quotient bit of the two pipelined normal divisions (x and y).
// Depends on cwr_pkg.
`timescale 1ns / 1ps

module cwr_div_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  cwr_pkg::div_type  data_in,
   input  cwr_pkg::side_type side_in,
   output logic              valid_out,
   output cwr_pkg::div_type  data_out,
   output cwr_pkg::side_type side_out
);
   import cwr_pkg::*;

   localparam logic [17:0] QBIT = 18'd1 << STEP;

   logic        valid_ff;
   div_type     data_ff, data_in_n;
   side_type    side_ff;
   logic [50:0] shifted, ext_x, ext_y;

   always_comb begin
      shifted   = 51'(data_in.den) << STEP;
      ext_x     = 51'(data_in.rem_x);
      ext_y     = 51'(data_in.rem_y);
      data_in_n = data_in;
      if (ext_x >= shifted) begin
         data_in_n.rem_x = 48'(ext_x - shifted);
         data_in_n.q_x   = data_in.q_x | QBIT;
      end
      if (ext_y >= shifted) begin
         data_in_n.rem_y = 48'(ext_y - shifted);
         data_in_n.q_y   = data_in.q_y | QBIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_n;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
   assign side_out  = side_ff;
endmodule

@@ rtl/circle_wall_collision_response_unit.sv @@
// A transaction accepted at one edge gives its result, with rsp_strobe high, once it has
// passed the input stages, 32 square-root cells, 18 divide cells and the output stages.
// Throughput: one transaction per cycle; busy is low except during reset.
// Reset: synchronous, clears all valid bits and loads restitution with 0.6.
// Depends on cwr_pkg, cwr_sqrt_cell and cwr_div_cell.
`timescale 1ns / 1ps

module circle_wall_collision_response_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cwr_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output cwr_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [16:0]      csr_write_data
);
   import cwr_pkg::*;

   logic [16:0] rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= REST_RESET;
      end else if (csr_write_enable) begin
         rest_ff <= csr_write_data;
      end
   end

   assign busy = reset;

   // input stage
   logic    v0_ff;
   req_type r0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff <= req_payload;
   end

   // clamp, offset and face selection
   logic signed [33:0] px, py, rl, rt, rr, rb, cx, cy, dx, dy;
   logic signed [35:0] rad, dl, dr, dt, db;
   side_type           s1_in;
   logic               v1_ff;
   side_type           s1_ff;

   always_comb begin
      px  = 34'(r0_ff.pos_x);
      py  = 34'(r0_ff.pos_y);
      rl  = 34'(r0_ff.rect_left);
      rt  = 34'(r0_ff.rect_top);
      rr  = rl + $signed({3'b000, r0_ff.rect_width});
      rb  = rt + $signed({3'b000, r0_ff.rect_height});
      rad = $signed({5'b00000, r0_ff.circle_radius});
      cx  = (px < rl) ? rl : ((px > rr) ? rr : px);
      cy  = (py < rt) ? rt : ((py > rb) ? rb : py);
      dx  = px - cx;
      dy  = py - cy;
      dl  = 36'(px) - 36'(rl);
      dr  = 36'(rr) - 36'(px);
      dt  = 36'(py) - 36'(rt);
      db  = 36'(rb) - 36'(py);
      s1_in.cx     = cx;
      s1_in.cy     = cy;
      s1_in.dx_neg = dx[33];
      s1_in.dy_neg = dy[33];
      s1_in.ax     = dx[33] ? 32'(-dx) : dx[31:0];
      s1_in.ay     = dy[33] ? 32'(-dy) : dy[31:0];
      s1_in.shift  = 1'b0;
      s1_in.vx     = r0_ff.vel_x;
      s1_in.vy     = r0_ff.vel_y;
      s1_in.radius = r0_ff.circle_radius;
      s1_in.in_npx = 36'(px);
      s1_in.in_npy = 36'(py);
      if (dx != 34'sd0 || dy != 34'sd0) begin
         s1_in.contact = CASE_OUTSIDE;
      end else if (dl <= dr && dl <= dt && dl <= db) begin
         s1_in.contact = CASE_LEFT;
         s1_in.in_npx  = 36'(rl) - rad;
      end else if (dr <= dt && dr <= db) begin
         s1_in.contact = CASE_RIGHT;
         s1_in.in_npx  = 36'(rr) + rad;
      end else if (dt <= db) begin
         s1_in.contact = CASE_TOP;
         s1_in.in_npy  = 36'(rt) - rad;
      end else begin
         s1_in.contact = CASE_BOTTOM;
         s1_in.in_npy  = 36'(rb) + rad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // squared length
   logic        shift_in;
   logic [30:0] sx, sy;
   logic        v2_ff;
   side_type    s2_ff, s2_in;
   sqrt_type    q2_ff, q2_in;

   always_comb begin
      shift_in    = s1_ff.ax[31] | s1_ff.ay[31];
      sx          = shift_in ? s1_ff.ax[31:1] : s1_ff.ax[30:0];
      sy          = shift_in ? s1_ff.ay[31:1] : s1_ff.ay[30:0];
      s2_in       = s1_ff;
      s2_in.shift = shift_in;
      q2_in.rem   = 64'(sx * sx) + 64'(sy * sy);
      q2_in.root  = 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      q2_ff <= q2_in;
   end

   // square-root chain
   logic     sq_v [SQRT_STEPS+1];
   sqrt_type sq_d [SQRT_STEPS+1];
   side_type sq_s [SQRT_STEPS+1];

   assign sq_v[0] = v2_ff;
   assign sq_d[0] = q2_ff;
   assign sq_s[0] = s2_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      cwr_sqrt_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_in (sq_v[i]),
         .data_in  (sq_d[i]),
         .side_in  (sq_s[i]),
         .valid_out(sq_v[i+1]),
         .data_out (sq_d[i+1]),
         .side_out (sq_s[i+1])
      );
   end

   // divide chain
   logic [32:0] len;
   logic        dv_v [DIV_STEPS+1];
   div_type     dv_d [DIV_STEPS+1];
   side_type    dv_s [DIV_STEPS+1];

   always_comb begin
      len = sq_s[SQRT_STEPS].shift ? {sq_d[SQRT_STEPS].root[31:0], 1'b0}
                                   : {1'b0, sq_d[SQRT_STEPS].root[31:0]};
      if (len == 33'd0) begin
         len = 33'd1;
      end
      dv_d[0].rem_x = {sq_s[SQRT_STEPS].ax, 16'd0};
      dv_d[0].rem_y = {sq_s[SQRT_STEPS].ay, 16'd0};
      dv_d[0].q_x   = 18'd0;
      dv_d[0].q_y   = 18'd0;
      dv_d[0].den   = len;
   end

   assign dv_v[0] = sq_v[SQRT_STEPS];
   assign dv_s[0] = sq_s[SQRT_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      cwr_div_cell #(.STEP(DIV_STEPS - 1 - i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_in (dv_v[i]),
         .data_in  (dv_d[i]),
         .side_in  (dv_s[i]),
         .valid_out(dv_v[i+1]),
         .data_out (dv_d[i+1]),
         .side_out (dv_s[i+1])
      );
   end

   // normal and products
   side_type           sd;
   logic signed [19:0] nx_in, ny_in, qx_s, qy_s;
   logic               b1_v_ff;
   side_type           b1_s_ff;
   logic signed [19:0] b1_nx_ff, b1_ny_ff;
   logic [48:0]        b1_pxr_ff, b1_pyr_ff;
   logic signed [51:0] b1_vxn_ff, b1_vyn_ff;

   always_comb begin
      sd   = dv_s[DIV_STEPS];
      qx_s = $signed({2'b00, dv_d[DIV_STEPS].q_x});
      qy_s = $signed({2'b00, dv_d[DIV_STEPS].q_y});
      nx_in = 20'sd0;
      ny_in = 20'sd0;
      case (sd.contact)
         CASE_OUTSIDE: begin
            nx_in = sd.dx_neg ? -qx_s : qx_s;
            ny_in = sd.dy_neg ? -qy_s : qy_s;
         end
         CASE_LEFT:   nx_in = -20'(Q_ONE);
         CASE_RIGHT:  nx_in = 20'(Q_ONE);
         CASE_TOP:    ny_in = -20'(Q_ONE);
         CASE_BOTTOM: ny_in = 20'(Q_ONE);
         default: begin
            nx_in = 20'sd0;
            ny_in = 20'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
      end else begin
         b1_v_ff <= dv_v[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      b1_s_ff   <= sd;
      b1_nx_ff  <= nx_in;
      b1_ny_ff  <= ny_in;
      b1_pxr_ff <= 49'(dv_d[DIV_STEPS].q_x) * 49'(sd.radius);
      b1_pyr_ff <= 49'(dv_d[DIV_STEPS].q_y) * 49'(sd.radius);
      b1_vxn_ff <= 52'(sd.vx) * 52'(nx_in);
      b1_vyn_ff <= 52'(sd.vy) * 52'(ny_in);
   end

   // position, dot product
   logic signed [35:0] offx, offy, npx_in, npy_in;
   logic signed [52:0] dot;
   logic               b2_v_ff, b2_bounced_ff;
   logic signed [31:0] b2_npx_ff, b2_npy_ff, b2_vx_ff, b2_vy_ff;
   logic signed [19:0] b2_nx_ff, b2_ny_ff;
   logic signed [36:0] b2_vin_ff;
   case_type           b2_case_ff;

   always_comb begin
      offx = $signed({3'b000, b1_pxr_ff[48:16]});
      offy = $signed({3'b000, b1_pyr_ff[48:16]});
      if (b1_s_ff.dx_neg) begin
         offx = -offx;
      end
      if (b1_s_ff.dy_neg) begin
         offy = -offy;
      end
      if (b1_s_ff.contact == CASE_OUTSIDE) begin
         npx_in = 36'(b1_s_ff.cx) + offx;
         npy_in = 36'(b1_s_ff.cy) + offy;
      end else begin
         npx_in = b1_s_ff.in_npx;
         npy_in = b1_s_ff.in_npy;
      end
      dot = 53'(b1_vxn_ff) + 53'(b1_vyn_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_v_ff <= 1'b0;
      end else begin
         b2_v_ff <= b1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      b2_npx_ff     <= sat32(64'(npx_in));
      b2_npy_ff     <= sat32(64'(npy_in));
      b2_vx_ff      <= b1_s_ff.vx;
      b2_vy_ff      <= b1_s_ff.vy;
      b2_nx_ff      <= b1_nx_ff;
      b2_ny_ff      <= b1_ny_ff;
      b2_vin_ff     <= 37'(tdiv16(64'(dot)));
      b2_bounced_ff <= dot[52];
      b2_case_ff    <= b1_s_ff.contact;
   end

   // restitution scale
   logic [17:0]        coef;
   logic               b3_v_ff, b3_bounced_ff;
   logic signed [31:0] b3_npx_ff, b3_npy_ff, b3_vx_ff, b3_vy_ff;
   logic signed [19:0] b3_nx_ff, b3_ny_ff;
   logic signed [55:0] b3_prod_ff;
   case_type           b3_case_ff;

   assign coef = 18'(Q_ONE) + 18'(rest_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_v_ff <= 1'b0;
      end else begin
         b3_v_ff <= b2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      b3_npx_ff     <= b2_npx_ff;
      b3_npy_ff     <= b2_npy_ff;
      b3_vx_ff      <= b2_vx_ff;
      b3_vy_ff      <= b2_vy_ff;
      b3_nx_ff      <= b2_nx_ff;
      b3_ny_ff      <= b2_ny_ff;
      b3_prod_ff    <= $signed({38'd0, coef}) * 56'(b2_vin_ff);
      b3_bounced_ff <= b2_bounced_ff;
      b3_case_ff    <= b2_case_ff;
   end

   // velocity change products
   logic signed [39:0] kval;
   logic               b4_v_ff, b4_bounced_ff;
   logic signed [31:0] b4_npx_ff, b4_npy_ff, b4_vx_ff, b4_vy_ff;
   logic signed [59:0] b4_mx_ff, b4_my_ff;
   case_type           b4_case_ff;

   assign kval = 40'(tdiv16(64'(b3_prod_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         b4_v_ff <= 1'b0;
      end else begin
         b4_v_ff <= b3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      b4_npx_ff     <= b3_npx_ff;
      b4_npy_ff     <= b3_npy_ff;
      b4_vx_ff      <= b3_vx_ff;
      b4_vy_ff      <= b3_vy_ff;
      b4_mx_ff      <= 60'(b3_nx_ff) * 60'(kval);
      b4_my_ff      <= 60'(b3_ny_ff) * 60'(kval);
      b4_bounced_ff <= b3_bounced_ff;
      b4_case_ff    <= b3_case_ff;
   end

   // output register
   logic    out_v_ff;
   rsp_type out_ff, out_in;

   always_comb begin
      out_in.new_pos_x    = b4_npx_ff;
      out_in.new_pos_y    = b4_npy_ff;
      out_in.new_vel_x    = b4_vx_ff;
      out_in.new_vel_y    = b4_vy_ff;
      out_in.contact_case = b4_case_ff;
      out_in.bounced      = b4_bounced_ff;
      if (b4_bounced_ff) begin
         out_in.new_vel_x = sat32(64'(b4_vx_ff) - tdiv16(64'(b4_mx_ff)));
         out_in.new_vel_y = sat32(64'(b4_vy_ff) - tdiv16(64'(b4_my_ff)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= b4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_strobe  = out_v_ff;
   assign rsp_payload = out_ff;
endmodule

@@ rtl/cwr_checker.sv @@
// Port-level checks for the collision response unit, bound to the top level.
// Depends on cwr_pkg and circle_wall_collision_response_unit.
`timescale 1ns / 1ps

module cwr_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input cwr_pkg::req_type req_payload,
   input logic             rsp_strobe,
   input cwr_pkg::rsp_type rsp_payload
);
   import cwr_pkg::*;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("transaction result missing");

   a_no_spurious: assert property (@(posedge clock)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without transaction");

   a_vel_kept: assert property (@(posedge clock)
      (rsp_strobe && !rsp_payload.bounced) |->
         (rsp_payload.new_vel_x == $past(req_payload.vel_x, LATENCY) &&
          rsp_payload.new_vel_y == $past(req_payload.vel_y, LATENCY)))
      else $error("velocity changed without bounce");

   a_face_x_kept: assert property (@(posedge clock)
      (rsp_strobe && (rsp_payload.contact_case == CASE_TOP ||
                      rsp_payload.contact_case == CASE_BOTTOM)) |->
         (rsp_payload.new_pos_x == $past(req_payload.pos_x, LATENCY) &&
          rsp_payload.new_vel_x == $past(req_payload.vel_x, LATENCY)))
      else $error("horizontal state changed on vertical face");
endmodule

bind circle_wall_collision_response_unit cwr_port_checks u_cwr_port_checks (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_payload(req_payload),
   .rsp_strobe (rsp_strobe),
   .rsp_payload(rsp_payload)
);
